// ----- rtl/rurx_pkg.sv -----
// ============================================================================
// rurx_pkg
// Shared types and constants for the reliable transfer receiver.
// ============================================================================
package rurx_pkg;

    localparam int SEQ_W    = 32;
    localparam int TIMER_W  = 16;
    localparam int LEN_W    = 32;
    localparam int RX_W     = 33;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    localparam logic [TIMER_W-1:0] TIMEOUT_RESET = TIMER_W'(1000);

    typedef enum logic [2:0] {
        PH_LISTEN    = 3'd0,
        PH_SYN_RCVD  = 3'd1,
        PH_CONNECTED = 3'd2,
        PH_DATA      = 3'd3,
        PH_LAST_ACK  = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        OUT_CTRL    = 2'd0,
        OUT_DELIVER = 2'd1,
        OUT_DONE    = 2'd2
    } out_kind_t;

    // What the back end has to emit for one item
    typedef enum logic [2:0] {
        ACT_CTRL      = 3'd0,   // one control packet
        ACT_CTRL_DONE = 3'd1,   // control packet, file complete
        ACT_DATA      = 3'd2,   // ACK, payload accepted
        ACT_DATA_DONE = 3'd3,   // ACK, payload accepted, file complete
        ACT_FIN_CLOSE = 3'd4    // ACK of FIN, then FIN+ACK
    } act_op_t;

    typedef struct packed {
        logic              kind;
        logic              is_syn;
        logic              is_ack;
        logic              is_fin;
        logic              is_header;
        logic              checksum_ok;
        logic [SEQ_W-1:0]  pkt_seq;
        logic [SEQ_W-1:0]  pkt_ack;
        logic [LEN_W-1:0]  pkt_length;
    } rx_item_t;

    typedef struct packed {
        out_kind_t         out_kind;
        logic              out_syn;
        logic              out_ackflag;
        logic              out_fin;
        logic [SEQ_W-1:0]  out_seq;
        logic [SEQ_W-1:0]  out_acknum;
        logic [LEN_W-1:0]  deliver_length;
        logic              last;
    } rx_result_t;

    typedef struct packed {
        act_op_t           op;
        logic              syn;
        logic              fin;
        logic [SEQ_W-1:0]  seq;
        logic [SEQ_W-1:0]  acknum;
        logic [LEN_W-1:0]  len;
    } act_t;

    typedef struct packed {
        logic valid;
        act_t act;
    } act_wr_t;

endpackage

// ----- rtl/rurx_front.sv -----
// ============================================================================
// rurx_front
// Accepts packets and ticks, runs the connection state, queues actions.
// ============================================================================
module rurx_front
    import rurx_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  rx_item_t            item,
    input  logic                cfg_we,
    input  logic [TIMER_W-1:0]  cfg_data,
    input  logic                q_full,
    output act_wr_t             q_wr
);

    phase_t              phase_reg, phase_next;
    logic [SEQ_W-1:0]    own_seq_reg, own_seq_next;
    logic [SEQ_W-1:0]    exp_seq_reg, exp_seq_next;
    logic [LEN_W-1:0]    file_size_reg, file_size_next;
    logic [RX_W-1:0]     rx_bytes_reg, rx_bytes_next;
    logic [TIMER_W-1:0]  idle_reg, idle_next;
    logic [TIMER_W-1:0]  timeout_reg;

    logic                accept;
    logic                tick;
    logic                ok;
    logic [TIMER_W-1:0]  idle_inc;
    logic                fire;
    logic [TIMER_W-1:0]  idle_after_tick;
    logic                seq_hit;
    logic                ack_hit;
    logic [RX_W:0]       rx_sum;
    logic [RX_W-1:0]     rx_sat;
    logic                rx_done;
    logic [SEQ_W-1:0]    exp_dec;
    logic [SEQ_W-1:0]    own_dec;
    logic [SEQ_W-1:0]    pseq_inc;

    assign item_ready = !q_full;
    assign accept     = item_valid && !q_full;
    assign tick       = item.kind;
    assign ok         = item.checksum_ok;

    assign idle_inc        = (idle_reg == '1) ? idle_reg : idle_reg + TIMER_W'(1);
    assign fire            = idle_inc >= timeout_reg;
    assign idle_after_tick = fire ? '0 : idle_inc;

    assign seq_hit  = item.pkt_seq == exp_seq_reg;
    assign ack_hit  = item.pkt_ack == own_seq_reg;
    assign exp_dec  = exp_seq_reg - SEQ_W'(1);
    assign own_dec  = own_seq_reg - SEQ_W'(1);
    assign pseq_inc = item.pkt_seq + SEQ_W'(1);

    // saturating byte count
    assign rx_sum  = {1'b0, rx_bytes_reg} + (RX_W + 1)'(item.pkt_length);
    assign rx_sat  = rx_sum[RX_W] ? '1 : rx_sum[RX_W-1:0];
    assign rx_done = rx_sat >= RX_W'(file_size_reg);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_SYN_RCVD:
                begin
                    if (!tick && ok && item.is_ack && ack_hit)
                        phase_next = PH_CONNECTED;
                end
                PH_CONNECTED:
                begin
                    if (!tick && ok && item.is_header)
                    begin
                        if (seq_hit && item.pkt_length != '0)
                            phase_next = PH_DATA;
                    end
                    else if (!tick && ok && item.is_fin)
                        phase_next = PH_LAST_ACK;
                end
                PH_DATA:
                begin
                    if (!tick && ok && seq_hit && rx_done)
                        phase_next = PH_CONNECTED;
                end
                PH_LAST_ACK:
                begin
                    if (!tick && ok && item.is_ack && ack_hit)
                        phase_next = PH_LISTEN;
                end
                default:
                begin
                    phase_next = (!tick && ok && item.is_syn) ? PH_SYN_RCVD : PH_LISTEN;
                end
            endcase
        end
    end

    // datapath updates and queued action
    always_comb
    begin
        own_seq_next   = own_seq_reg;
        exp_seq_next   = exp_seq_reg;
        file_size_next = file_size_reg;
        rx_bytes_next  = rx_bytes_reg;
        idle_next      = idle_reg;
        q_wr           = '0;
        q_wr.act.op    = ACT_CTRL;
        if (accept)
        begin
            unique case (phase_reg)
                PH_SYN_RCVD:
                begin
                    if (tick)
                    begin
                        idle_next         = idle_after_tick;
                        q_wr.valid        = fire;
                        q_wr.act.syn      = 1'b1;
                        q_wr.act.seq      = own_seq_reg;
                        q_wr.act.acknum   = own_dec;
                    end
                    else if (ok && item.is_ack && ack_hit)
                    begin
                        own_seq_next = item.pkt_seq;
                        exp_seq_next = pseq_inc;
                        idle_next    = '0;
                    end
                end
                PH_CONNECTED:
                begin
                    if (tick)
                    begin
                        idle_next       = idle_after_tick;
                        q_wr.valid      = fire;
                        q_wr.act.acknum = exp_dec;
                    end
                    else if (ok && item.is_header)
                    begin
                        q_wr.valid = 1'b1;
                        if (seq_hit)
                        begin
                            file_size_next  = item.pkt_length;
                            rx_bytes_next   = '0;
                            exp_seq_next    = pseq_inc;
                            idle_next       = '0;
                            q_wr.act.acknum = item.pkt_seq;
                            if (item.pkt_length == '0)
                            begin
                                q_wr.act.op  = ACT_CTRL_DONE;
                                own_seq_next = item.pkt_seq;
                            end
                        end
                        else
                            q_wr.act.acknum = exp_dec;
                    end
                    else if (ok && item.is_fin)
                    begin
                        q_wr.valid      = 1'b1;
                        q_wr.act.op     = ACT_FIN_CLOSE;
                        q_wr.act.seq    = pseq_inc;
                        q_wr.act.acknum = item.pkt_seq;
                        own_seq_next    = item.pkt_seq + SEQ_W'(2);
                        idle_next       = '0;
                    end
                end
                PH_DATA:
                begin
                    if (tick)
                    begin
                        idle_next       = idle_after_tick;
                        q_wr.valid      = fire;
                        q_wr.act.acknum = exp_dec;
                    end
                    else
                    begin
                        idle_next = '0;
                        if (ok && seq_hit)
                        begin
                            q_wr.valid      = 1'b1;
                            q_wr.act.op     = rx_done ? ACT_DATA_DONE : ACT_DATA;
                            q_wr.act.acknum = item.pkt_seq;
                            q_wr.act.len    = item.pkt_length;
                            rx_bytes_next   = rx_sat;
                            exp_seq_next    = pseq_inc;
                            if (rx_done)
                                own_seq_next = item.pkt_seq;
                        end
                        else if (ok)
                        begin
                            q_wr.valid      = 1'b1;
                            q_wr.act.acknum = exp_dec;
                        end
                    end
                end
                PH_LAST_ACK:
                begin
                    if (tick)
                    begin
                        idle_next       = idle_after_tick;
                        q_wr.valid      = fire;
                        q_wr.act.fin    = 1'b1;
                        q_wr.act.seq    = own_seq_reg;
                        q_wr.act.acknum = own_dec;
                    end
                    else if (ok && item.is_ack && ack_hit)
                        idle_next = '0;
                end
                default:
                begin
                    if (!tick && ok && item.is_syn)
                    begin
                        own_seq_next    = pseq_inc;
                        idle_next       = '0;
                        q_wr.valid      = 1'b1;
                        q_wr.act.syn    = 1'b1;
                        q_wr.act.seq    = pseq_inc;
                        q_wr.act.acknum = item.pkt_seq;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LISTEN;
            own_seq_reg   <= '0;
            exp_seq_reg   <= '0;
            file_size_reg <= '0;
            rx_bytes_reg  <= '0;
            idle_reg      <= '0;
            timeout_reg   <= TIMEOUT_RESET;
        end
        else
        begin
            phase_reg     <= phase_next;
            own_seq_reg   <= own_seq_next;
            exp_seq_reg   <= exp_seq_next;
            file_size_reg <= file_size_next;
            rx_bytes_reg  <= rx_bytes_next;
            idle_reg      <= idle_next;
            if (cfg_we)
                timeout_reg <= cfg_data;
        end
    end

endmodule

// ----- rtl/rurx_queue.sv -----
// ============================================================================
// rurx_queue
// Short action queue between the front and back ends.
// ============================================================================
module rurx_queue
    import rurx_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  act_wr_t  q_wr,
    output logic     q_full,
    input  logic     q_pop,
    output logic     q_head_valid,
    output act_t     q_head
);

    act_t               mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_push;

    assign q_full       = count_reg == QCNT_W'(QDEPTH);
    assign q_head_valid = count_reg != '0;
    assign q_head       = mem_reg[rd_ptr_reg];
    assign do_push      = q_wr.valid && !q_full;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(do_push) - QCNT_W'(q_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= q_wr.act;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/rurx_back.sv -----
// ============================================================================
// rurx_back
// Expands queued actions into result words, one per cycle unless stalled.
// ============================================================================
module rurx_back
    import rurx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_head_valid,
    input  act_t        q_head,
    output logic        q_pop,
    output logic        res_valid,
    input  logic        res_ready,
    output rx_result_t  res
);

    logic [1:0]  step_reg, step_next;
    logic        valid_reg, valid_next;
    rx_result_t  res_reg, res_next;
    logic        load;
    logic        last_step;

    assign load      = q_head_valid && (!valid_reg || res_ready);
    assign res_valid = valid_reg;
    assign res       = res_reg;

    // result word for the current step of the head action
    always_comb
    begin
        res_next             = '0;
        res_next.out_kind    = OUT_CTRL;
        res_next.out_syn     = q_head.syn;
        res_next.out_ackflag = 1'b1;
        res_next.out_fin     = q_head.fin;
        res_next.out_seq     = q_head.seq;
        res_next.out_acknum  = q_head.acknum;
        last_step            = 1'b1;
        if (step_reg == 2'd0)
            last_step = q_head.op == ACT_CTRL;
        else if (step_reg == 2'd1)
        begin
            res_next = '0;
            unique case (q_head.op)
                ACT_DATA, ACT_DATA_DONE:
                begin
                    res_next.out_kind       = OUT_DELIVER;
                    res_next.deliver_length = q_head.len;
                    last_step               = q_head.op == ACT_DATA;
                end
                ACT_FIN_CLOSE:
                begin
                    res_next.out_kind    = OUT_CTRL;
                    res_next.out_ackflag = 1'b1;
                    res_next.out_fin     = 1'b1;
                    res_next.out_seq     = q_head.seq + SEQ_W'(1);
                    res_next.out_acknum  = q_head.acknum + SEQ_W'(1);
                end
                default:
                begin
                    res_next.out_kind = OUT_DONE;
                end
            endcase
        end
        else
        begin
            res_next          = '0;
            res_next.out_kind = OUT_DONE;
        end
        res_next.last = last_step;
    end

    assign q_pop = load && last_step;

    always_comb
    begin
        step_next  = step_reg;
        valid_next = valid_reg;
        if (load)
        begin
            step_next  = last_step ? 2'd0 : step_reg + 2'd1;
            valid_next = 1'b1;
        end
        else if (res_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

endmodule

// ----- rtl/reliable_udp_receiver_fsm.sv -----
// ============================================================================
// reliable_udp_receiver_fsm
// Stop-and-wait receiver: handshake, in-order data with cumulative ACKs,
// teardown.
// ============================================================================
// The block takes one item per cycle, packet header or timer tick, as long
// as its four-entry action queue has room; the front end updates the
// connection state in that same cycle and queues at most one action. The
// back end turns each action into one to three result words and hands out
// one word per cycle while res_ready is high, through a registered output;
// each word of an item takes its own turn on the result port, so the port
// sets the sustained rate whenever most items produce more than one word,
// and the queue absorbs short bursts. Items that produce nothing never touch
// the queue's output side. A result is held in the output register until
// taken while the front end keeps accepting. The timeout register is written
// through cfg_we and cfg_data and takes effect on the next tick; write it
// only while the block is idle.
// ============================================================================
module reliable_udp_receiver_fsm
    import rurx_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  rx_item_t            item,
    output logic                res_valid,
    input  logic                res_ready,
    output rx_result_t          res,
    input  logic                cfg_we,
    input  logic [TIMER_W-1:0]  cfg_data
);

    act_wr_t  q_wr;
    logic     q_full;
    logic     q_pop;
    logic     q_head_valid;
    act_t     q_head;

    // Front end: classify the item, advance the connection, queue an action
    rurx_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .q_full     (q_full),
        .q_wr       (q_wr)
    );

    // Decouple the two sides
    rurx_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_wr         (q_wr),
        .q_full       (q_full),
        .q_pop        (q_pop),
        .q_head_valid (q_head_valid),
        .q_head       (q_head)
    );

    // Back end: emit result words, drop the action after its final word
    rurx_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_head_valid (q_head_valid),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res)
    );

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_wr.valid |-> !q_full)
        else $error("action queued while queue full");

    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_head_valid)
        else $error("action dropped from empty queue");

    a_noncontrol_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.out_kind != OUT_CTRL)
            |-> (!res.out_syn && !res.out_ackflag && !res.out_fin))
        else $error("control flags set on a delivery or completion word");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.out_kind == OUT_DONE) |-> res.last)
        else $error("file complete word not marked last");
`endif

endmodule
